// File: rtl/frame_rate_limiter_core_macros.svh
// Assertion macros shared by the frame rate limiter RTL.
`ifndef FRAME_RATE_LIMITER_CORE_MACROS_SVH
`define FRAME_RATE_LIMITER_CORE_MACROS_SVH
`ifndef SYNTHESIS
// Check prop on every clock edge outside reset.
`define FRL_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);
// Check that consq holds on the edge after cond.
`define FRL_ASSERT_NEXT(label, cond, consq, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond) |=> (consq)) else $error(msg);
`else
`define FRL_ASSERT(label, prop, msg)
`define FRL_ASSERT_NEXT(label, cond, consq, msg)
`endif
`endif

// File: rtl/frl_pkg.sv
// Shared constants and types for the frame rate limiter.
`default_nettype none
package frl_pkg;

    localparam int WINDOW    = 10;
    localparam int TICK_W    = 32;
    localparam int SAMPLE_W  = 16;
    localparam int CFG_W     = 10;
    localparam int FPS_W     = 22;
    localparam int SLEEP_W   = 10;
    localparam int APB_W     = 32;
    localparam int PADDR_W   = 3;

    localparam int IDX_W     = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W     = $clog2(WINDOW + 1);
    localparam int SUM_W     = $clog2(WINDOW * 65535 + 1);

    // 1000 ms per second times 256 for the Q.8 fraction
    localparam int FPS_SCALE = 256000;
    localparam int DVD_W     = $clog2(WINDOW * FPS_SCALE + 1);
    localparam int DSR_W     = (SUM_W > CFG_W) ? SUM_W : CFG_W;
    localparam int STEP_W    = $clog2(DVD_W + 1);

    localparam int BUDGET_MS      = 1000;
    localparam int FRAME_SAT      = 65535;
    localparam int FPS_DEFAULT_Q8 = 15360;
    localparam int FPS_MAX_Q8     = 4194303;
    localparam int MAX_FPS_RESET  = 60;

    // register index, taken from paddr[2]
    localparam logic REG_MAX_FPS = 1'b0;

    typedef struct packed {
        logic load;     // compute frame time, retire the oldest sample
        logic commit;   // write the sample, update sum and pointers
    } t_ring_ctl;

    typedef struct packed {
        logic              start;
        logic [STEP_W-1:0] steps;
    } t_div_req;

endpackage
`default_nettype wire

// File: rtl/frl_ring.sv
// Frame time sample ring with running sum, fill count and previous end tick.
`default_nettype none
`include "frame_rate_limiter_core_macros.svh"
module frl_ring (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire frl_pkg::t_ring_ctl            i_ctl,
    input  wire logic [frl_pkg::TICK_W-1:0]    i_frame_end,
    output logic      [frl_pkg::SAMPLE_W-1:0]  o_frame_ms,
    output logic      [frl_pkg::SUM_W-1:0]     o_sum,
    output logic      [frl_pkg::CNT_W-1:0]     o_fill
);
    localparam int WINDOW   = frl_pkg::WINDOW;
    localparam int IDX_W    = frl_pkg::IDX_W;
    localparam int CNT_W    = frl_pkg::CNT_W;
    localparam int SUM_W    = frl_pkg::SUM_W;
    localparam int SAMPLE_W = frl_pkg::SAMPLE_W;
    localparam int TICK_W   = frl_pkg::TICK_W;

    logic [SAMPLE_W-1:0] r_mem [WINDOW];
    logic [SAMPLE_W-1:0] r_old;
    logic [SAMPLE_W-1:0] r_frame;
    logic [IDX_W-1:0]    r_idx;
    logic [CNT_W-1:0]    r_fill;
    logic [SUM_W-1:0]    r_sum;
    logic [TICK_W-1:0]   r_prev_end;
    logic                r_seen;

    logic [TICK_W-1:0]   delta;
    logic [SAMPLE_W-1:0] frame_sat;
    logic                full;

    assign delta     = i_frame_end - r_prev_end;
    assign frame_sat = (delta > TICK_W'(frl_pkg::FRAME_SAT)) ? SAMPLE_W'(frl_pkg::FRAME_SAT)
                                                             : delta[SAMPLE_W-1:0];
    assign full      = (r_fill == CNT_W'(WINDOW));

    // sample memory: read the slot about to be overwritten every cycle
    always_ff @(posedge i_clk) begin
        r_old <= r_mem[r_idx];
        if (i_ctl.commit) begin
            r_mem[r_idx] <= r_frame;
        end
        if (i_ctl.load) begin
            r_frame <= r_seen ? frame_sat : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx      <= '0;
            r_fill     <= '0;
            r_sum      <= '0;
            r_prev_end <= '0;
            r_seen     <= 1'b0;
        end else if (i_ctl.load) begin
            r_seen     <= 1'b1;
            r_prev_end <= i_frame_end;
            if (full) begin
                r_sum <= r_sum - SUM_W'(r_old);
            end
        end else if (i_ctl.commit) begin
            r_sum <= r_sum + SUM_W'(r_frame);
            r_idx <= (r_idx == IDX_W'(WINDOW - 1)) ? '0 : r_idx + 1'b1;
            if (!full) begin
                r_fill <= r_fill + 1'b1;
            end
        end
    end

    assign o_frame_ms = r_frame;
    assign o_sum      = r_sum;
    assign o_fill     = r_fill;

    `FRL_ASSERT(a_fill_bound, r_fill <= CNT_W'(WINDOW), "fill count beyond window")
    `FRL_ASSERT(a_idx_bound, r_idx <= IDX_W'(WINDOW - 1), "ring index beyond window")
    `FRL_ASSERT(a_empty_sum, (r_fill == '0) |-> (r_sum == '0), "sum nonzero with empty ring")

endmodule
`default_nettype wire

// File: rtl/frl_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
`default_nettype none
module frl_div (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire frl_pkg::t_div_req           i_req,
    input  wire logic [frl_pkg::DVD_W-1:0]   i_dividend,
    input  wire logic [frl_pkg::DSR_W-1:0]   i_divisor,
    output logic                             o_busy,
    output logic      [frl_pkg::DVD_W-1:0]   o_quotient
);
    localparam int DVD_W  = frl_pkg::DVD_W;
    localparam int DSR_W  = frl_pkg::DSR_W;
    localparam int STEP_W = frl_pkg::STEP_W;

    logic              r_busy;
    logic [STEP_W-1:0] r_cnt;
    logic [DVD_W-1:0]  r_dvd;
    logic [DSR_W-1:0]  r_dsr;
    logic [DSR_W-1:0]  r_rem;

    logic [DSR_W:0]    shifted;
    logic              fits;

    // bring down the next dividend bit and try the subtract
    assign shifted = {r_rem, r_dvd[DVD_W-1]};
    assign fits    = (shifted >= {1'b0, r_dsr});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
        end else if (r_busy && (r_cnt == STEP_W'(1))) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_cnt <= i_req.steps;
            r_dvd <= i_dividend;
            r_dsr <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            r_dvd <= {r_dvd[DVD_W-2:0], fits};
            r_rem <= fits ? DSR_W'(shifted - {1'b0, r_dsr}) : shifted[DSR_W-1:0];
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_dvd;

endmodule
`default_nettype wire

// File: rtl/frame_rate_limiter_core.sv
// Top level of the moving-average frame rate meter and frame budget limiter.
//
// One word per frame carries its start and end millisecond ticks; one result word
// comes back with the averaged rate (Q.8), the sleep time left in the frame budget
// and the frame time. Frame times come from the end tick minus the previous end
// tick, saturate at 65535 and feed a ring of the last WINDOW samples. Both the
// budget (1000 / max_fps) and the rate (256000 * count / sum) come out of one
// bit-serial divider, 10 steps for the budget and DVD_W steps for the rate; the
// rate division is skipped when the sum is zero. The block holds off new words
// while one is in work; a finished result waits in the output register without
// blocking the next word. max_fps sits at byte address 0 and is to be written
// only while the block is idle; the block itself does not enforce this.
`default_nettype none
`include "frame_rate_limiter_core_macros.svh"
module frame_rate_limiter_core (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic [frl_pkg::TICK_W-1:0]    i_frame_start,
    input  wire logic [frl_pkg::TICK_W-1:0]    i_frame_end,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic      [frl_pkg::FPS_W-1:0]     o_fps_q8,
    output logic      [frl_pkg::SLEEP_W-1:0]   o_sleep_ms,
    output logic      [frl_pkg::SAMPLE_W-1:0]  o_frame_ms,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [frl_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [frl_pkg::APB_W-1:0]     pwdata,
    output logic      [frl_pkg::APB_W-1:0]     prdata,
    output logic                               pready
);
    localparam int TICK_W   = frl_pkg::TICK_W;
    localparam int CFG_W    = frl_pkg::CFG_W;
    localparam int FPS_W    = frl_pkg::FPS_W;
    localparam int SLEEP_W  = frl_pkg::SLEEP_W;
    localparam int SAMPLE_W = frl_pkg::SAMPLE_W;
    localparam int APB_W    = frl_pkg::APB_W;
    localparam int SUM_W    = frl_pkg::SUM_W;
    localparam int CNT_W    = frl_pkg::CNT_W;
    localparam int DVD_W    = frl_pkg::DVD_W;
    localparam int DSR_W    = frl_pkg::DSR_W;
    localparam int STEP_W   = frl_pkg::STEP_W;
    localparam int SAT_W    = (DVD_W > FPS_W) ? DVD_W : FPS_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FRAME,
        S_SUM,
        S_BUDGET,
        S_FPS,
        S_DONE
    } t_state;

    t_state              r_state;
    t_state              n_state;

    logic [CFG_W-1:0]    r_max_fps;
    logic [TICK_W-1:0]   r_start;
    logic [TICK_W-1:0]   r_end;
    logic [TICK_W-1:0]   r_busy_ms;
    logic [SLEEP_W-1:0]  r_budget;
    logic [SLEEP_W-1:0]  r_sleep;
    logic [FPS_W-1:0]    r_fps;
    logic                r_out_valid;
    logic [FPS_W-1:0]    r_out_fps;
    logic [SLEEP_W-1:0]  r_out_sleep;
    logic [SAMPLE_W-1:0] r_out_frame;

    logic                in_take;
    logic                out_free;
    logic                cfg_write;

    frl_pkg::t_ring_ctl  ring_ctl;
    logic [SAMPLE_W-1:0] frame_ms;
    logic [SUM_W-1:0]    sum;
    logic [CNT_W-1:0]    fill;

    frl_pkg::t_div_req   div_req;
    logic [DVD_W-1:0]    div_dividend;
    logic [DSR_W-1:0]    div_divisor;
    logic                div_busy;
    logic [DVD_W-1:0]    div_quotient;

    logic [SAT_W-1:0]    quot_ext;
    logic [FPS_W-1:0]    fps_sat;
    logic [CFG_W-1:0]    fps_target;

    // ---------------- configuration port ----------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == frl_pkg::REG_MAX_FPS) ? APB_W'(r_max_fps) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_fps <= CFG_W'(frl_pkg::MAX_FPS_RESET);
        end else if (cfg_write && (paddr[2] == frl_pkg::REG_MAX_FPS)) begin
            r_max_fps <= pwdata[CFG_W-1:0];
        end
    end

    // ---------------- handshakes ----------------
    assign o_stall  = (r_state != S_IDLE) || !i_rst_n;
    assign in_take  = i_valid && !o_stall;
    assign out_free = !r_out_valid || !i_stall;

    // ---------------- datapath units ----------------
    assign ring_ctl.load   = (r_state == S_FRAME);
    assign ring_ctl.commit = (r_state == S_SUM);

    frl_ring u_ring (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (ring_ctl),
        .i_frame_end (r_end),
        .o_frame_ms  (frame_ms),
        .o_sum       (sum),
        .o_fill      (fill)
    );

    // zero max_fps counts as one frame per second
    assign fps_target = (r_max_fps == '0) ? CFG_W'(1) : r_max_fps;

    always_comb begin
        div_req.start = 1'b0;
        div_req.steps = STEP_W'(DVD_W);
        div_dividend  = DVD_W'(fill) * DVD_W'(frl_pkg::FPS_SCALE);
        div_divisor   = DSR_W'(sum);
        if (r_state == S_FRAME) begin
            // budget: left-align 1000 so its quotient lands in the low bits
            div_req.start = 1'b1;
            div_req.steps = STEP_W'(CFG_W);
            div_dividend  = DVD_W'(frl_pkg::BUDGET_MS) << (DVD_W - CFG_W);
            div_divisor   = DSR_W'(fps_target);
        end else if ((r_state == S_BUDGET) && !div_busy && (sum != '0)) begin
            div_req.start = 1'b1;
        end
    end

    frl_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (div_req),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_busy     (div_busy),
        .o_quotient (div_quotient)
    );

    assign quot_ext = SAT_W'(div_quotient);
    assign fps_sat  = (quot_ext > SAT_W'(frl_pkg::FPS_MAX_Q8)) ? FPS_W'(frl_pkg::FPS_MAX_Q8)
                                                               : quot_ext[FPS_W-1:0];

    // ---------------- sequencer ----------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_take) begin
                    n_state = S_FRAME;
                end
            end
            S_FRAME: begin
                n_state = S_SUM;
            end
            S_SUM: begin
                n_state = S_BUDGET;
            end
            S_BUDGET: begin
                if (!div_busy) begin
                    n_state = (sum == '0) ? S_DONE : S_FPS;
                end
            end
            S_FPS: begin
                if (!div_busy) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if ((r_state == S_DONE) && out_free) begin
                r_out_valid <= 1'b1;
                r_out_fps   <= r_fps;
                r_out_sleep <= r_sleep;
                r_out_frame <= frame_ms;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
            if (in_take) begin
                r_start <= i_frame_start;
                r_end   <= i_frame_end;
            end
            if (r_state == S_FRAME) begin
                r_busy_ms <= r_end - r_start;
            end
            if ((r_state == S_BUDGET) && !div_busy) begin
                r_budget <= div_quotient[SLEEP_W-1:0];
                r_sleep  <= (TICK_W'(div_quotient[SLEEP_W-1:0]) > r_busy_ms)
                            ? div_quotient[SLEEP_W-1:0] - r_busy_ms[SLEEP_W-1:0]
                            : '0;
                if (sum == '0) begin
                    r_fps <= FPS_W'(frl_pkg::FPS_DEFAULT_Q8);
                end
            end
            if ((r_state == S_FPS) && !div_busy) begin
                r_fps <= fps_sat;
            end
        end
    end

    assign o_valid    = r_out_valid;
    assign o_fps_q8   = r_out_fps;
    assign o_sleep_ms = r_out_sleep;
    assign o_frame_ms = r_out_frame;

    `FRL_ASSERT_NEXT(a_take_starts, in_take, r_state == S_FRAME, "accepted word did not start")
    `FRL_ASSERT(a_rise_from_done, $rose(o_valid) |-> $past(r_state == S_DONE),
        "result word appeared outside completion")
    `FRL_ASSERT(a_idle_div_quiet, (r_state == S_IDLE) |-> !div_busy, "divider running while idle")
    `FRL_ASSERT(a_sleep_in_budget, (r_state == S_DONE) |-> (r_sleep <= r_budget),
        "sleep time exceeds frame budget")

endmodule
`default_nettype wire

// File: tb/tb_frame_rate_limiter_core.sv
`timescale 1ns / 1ps
// Self-checking testbench for frame_rate_limiter_core: frame words in, rate and budget words out.
module tb_frame_rate_limiter_core;

    localparam int TICK_W         = frl_pkg::TICK_W;
    localparam int FPS_W          = frl_pkg::FPS_W;
    localparam int SLEEP_W        = frl_pkg::SLEEP_W;
    localparam int SAMPLE_W       = frl_pkg::SAMPLE_W;
    localparam int APB_W          = frl_pkg::APB_W;
    localparam int CFG_W          = frl_pkg::CFG_W;
    localparam int PADDR_W        = frl_pkg::PADDR_W;
    localparam int WINDOW         = frl_pkg::WINDOW;
    localparam int MAX_FPS_RESET  = frl_pkg::MAX_FPS_RESET;
    localparam int FRAME_SAT      = frl_pkg::FRAME_SAT;
    localparam int FPS_DEFAULT_Q8 = frl_pkg::FPS_DEFAULT_Q8;
    localparam int FPS_SCALE      = frl_pkg::FPS_SCALE;
    localparam int FPS_MAX_Q8     = frl_pkg::FPS_MAX_Q8;
    localparam int BUDGET_MS      = frl_pkg::BUDGET_MS;

    localparam int HALF_PERIOD = 6;
    localparam int IDLE_LIMIT  = 4000;
    localparam int LONG_HOLD   = 600;
    localparam int PHASES      = 10;
    localparam int RAND_FRAMES = 120;
    localparam logic [PADDR_W-1:0] MAX_FPS_ADDR = {frl_pkg::REG_MAX_FPS, 2'b00};

    typedef struct packed {
        logic [TICK_W-1:0] start_tick;
        logic [TICK_W-1:0] end_tick;
    } t_frame_word;

    typedef struct packed {
        logic [FPS_W-1:0]    fps_q8;
        logic [SLEEP_W-1:0]  sleep_ms;
        logic [SAMPLE_W-1:0] frame_ms;
    } t_rate_result;

    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                i_valid       = 1'b0;
    logic [TICK_W-1:0]   i_frame_start = '0;
    logic [TICK_W-1:0]   i_frame_end   = '0;
    logic                i_stall       = 1'b0;
    logic                psel          = 1'b0;
    logic                penable       = 1'b0;
    logic                pwrite        = 1'b0;
    logic [PADDR_W-1:0]  paddr         = '0;
    logic [APB_W-1:0]    pwdata        = '0;
    logic                o_stall;
    logic                o_valid;
    logic [FPS_W-1:0]    o_fps_q8;
    logic [SLEEP_W-1:0]  o_sleep_ms;
    logic [SAMPLE_W-1:0] o_frame_ms;
    logic [APB_W-1:0]    prdata;
    logic                pready;

    frame_rate_limiter_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_frame_start (i_frame_start),
        .i_frame_end   (i_frame_end),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_fps_q8      (o_fps_q8),
        .o_sleep_ms    (o_sleep_ms),
        .o_frame_ms    (o_frame_ms),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        i_clk = 1'b0;
        #HALF_PERIOD;
        i_clk = 1'b1;
        #HALF_PERIOD;
    end

    // Rate meter state, mirrored from the block
    logic [SAMPLE_W-1:0] sample_ring [WINDOW];
    int unsigned         ring_slot    = 0;
    int unsigned         sample_count = 0;
    int unsigned         window_sum   = 0;
    logic [TICK_W-1:0]   last_end     = '0;
    bit                  seen_frame   = 1'b0;
    int unsigned         target_fps   = MAX_FPS_RESET;

    t_frame_word  pending_frames [$];
    t_rate_result expected_results [$];
    int unsigned  errors = 0;

    initial begin
        for (int k = 0; k < WINDOW; k++) sample_ring[k] = '0;
    end

    function automatic t_rate_result rate_meter_step(t_frame_word w);
        logic [TICK_W-1:0]   delta;
        logic [TICK_W-1:0]   busy;
        logic [SAMPLE_W-1:0] sample;
        longint unsigned     quotient;
        int unsigned         budget;
        t_rate_result        r;
        sample = '0;
        if (seen_frame) begin
            delta  = w.end_tick - last_end;
            sample = (delta > TICK_W'(FRAME_SAT)) ? SAMPLE_W'(FRAME_SAT) : delta[SAMPLE_W-1:0];
        end
        seen_frame = 1'b1;
        last_end   = w.end_tick;
        // retire the oldest sample once the window is full
        if (sample_count >= WINDOW)
            window_sum -= sample_ring[ring_slot];
        else
            sample_count++;
        sample_ring[ring_slot] = sample;
        window_sum += sample;
        ring_slot = (ring_slot + 1) % WINDOW;
        if (window_sum == 0) begin
            quotient = FPS_DEFAULT_Q8;
        end else begin
            quotient = (64'(FPS_SCALE) * sample_count) / window_sum;
            if (quotient > FPS_MAX_Q8) quotient = FPS_MAX_Q8;
        end
        budget = BUDGET_MS / ((target_fps == 0) ? 1 : target_fps);
        busy   = w.end_tick - w.start_tick;
        r.fps_q8   = quotient[FPS_W-1:0];
        r.sleep_ms = (busy < budget) ? SLEEP_W'(budget - busy) : '0;
        r.frame_ms = sample;
        return r;
    endfunction

    // Driver: bursts of words with random gaps
    t_frame_word cur_frame;
    bit          word_held  = 1'b0;
    bit          present;
    int unsigned burst_left = 8;
    int unsigned gap_left   = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                expected_results.push_back(rate_meter_step(cur_frame));
                word_held = 1'b0;
            end
            if (!word_held) begin
                present = 1'b0;
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_frames.size() > 0) begin
                    cur_frame = pending_frames.pop_front();
                    word_held = 1'b1;
                    present   = 1'b1;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 20);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 60);
                    end else begin
                        burst_left--;
                    end
                end
                i_valid <= present;
                if (present) begin
                    i_frame_start <= cur_frame.start_tick;
                    i_frame_end   <= cur_frame.end_tick;
                end
            end
        end
    end

    // Monitor: check each result word and drive the stall pattern
    int unsigned  holds_asked  = 0;
    int unsigned  holds_served = 0;
    int unsigned  hold_left    = 0;
    int unsigned  stall_mode   = 0;
    int unsigned  stall_seg    = 0;
    int unsigned  cycle_cnt    = 0;
    bit           stall_next;
    t_rate_result want;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            cycle_cnt++;
            if (o_valid && !i_stall) begin
                if (expected_results.size() == 0) begin
                    errors++;
                    $display("%0t: result word with none expected: fps_q8 %0d",
                             $time, o_fps_q8);
                    $display("%0t: sleep_ms %0d frame_ms %0d", $time, o_sleep_ms, o_frame_ms);
                end else begin
                    want = expected_results.pop_front();
                    if (o_fps_q8 !== want.fps_q8) begin
                        errors++;
                        $display("%0t: fps_q8 expected %0d got %0d", $time, want.fps_q8, o_fps_q8);
                    end
                    if (o_sleep_ms !== want.sleep_ms) begin
                        errors++;
                        $display("%0t: sleep_ms expected %0d got %0d",
                                 $time, want.sleep_ms, o_sleep_ms);
                    end
                    if (o_frame_ms !== want.frame_ms) begin
                        errors++;
                        $display("%0t: frame_ms expected %0d got %0d",
                                 $time, want.frame_ms, o_frame_ms);
                    end
                end
            end
            if (holds_served != holds_asked) begin
                holds_served = holds_asked;
                hold_left    = LONG_HOLD;
            end
            if (stall_seg == 0) begin
                stall_mode = $urandom_range(0, 3);
                stall_seg  = $urandom_range(20, 300);
            end else begin
                stall_seg--;
            end
            if (hold_left > 0) begin
                hold_left--;
                stall_next = 1'b1;
            end else begin
                case (stall_mode)
                    0:       stall_next = 1'b0;
                    1:       stall_next = ($urandom_range(0, 7) == 0);
                    2:       stall_next = $urandom_range(0, 1);
                    default: stall_next = (cycle_cnt % 3 == 0);
                endcase
            end
            i_stall <= stall_next;
        end
    end

    // Watchdog: end the run when nothing moves for too long
    int unsigned idle_cycles = 0;

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || psel || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic write_max_fps(input int unsigned value);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= MAX_FPS_ADDR;
        pwdata  <= APB_W'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        target_fps = value;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        // read the register back
        @(posedge i_clk);
        psel <= 1'b1;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata[CFG_W-1:0] !== CFG_W'(value)) begin
            errors++;
            $display("%0t: max_fps readback expected %0d got %0d", $time, value, prdata);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic wait_until_drained();
        while (pending_frames.size() != 0 || word_held || expected_results.size() != 0)
            @(posedge i_clk);
    endtask

    function automatic void add_frame(logic [TICK_W-1:0] s, logic [TICK_W-1:0] e);
        t_frame_word w;
        w.start_tick = s;
        w.end_tick   = e;
        pending_frames.push_back(w);
    endfunction

    initial begin
        int unsigned       fps_settings [PHASES] = '{60, 1, 1000, 0, 1023, 7, 144, 0, 512, 3};
        int unsigned       budget_now;
        int unsigned       pick;
        logic [TICK_W-1:0] gen_end;
        logic [TICK_W-1:0] delta;
        logic [TICK_W-1:0] busy;
        logic [TICK_W-1:0] end_tick;
        fps_settings[7] = $urandom_range(2, 999);
        gen_end = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int phase = 0; phase < PHASES; phase++) begin
            write_max_fps(fps_settings[phase]);
            budget_now = BUDGET_MS / ((fps_settings[phase] == 0) ? 1 : fps_settings[phase]);
            if (phase == 0) begin
                // budget is 16 ms here
                add_frame(32'h0, 32'h0);                  // first frame
                add_frame(32'd0, 32'd10);
                add_frame(32'd10, 32'd26);                // busy equals budget
                add_frame(32'd27, 32'd42);                // busy one below budget
                add_frame(32'd50, 32'd40);                // end before start and before last end
                add_frame(32'hFFFF_FFF0, 32'hFFFF_FFFF);  // saturated frame time
                add_frame(32'hFFFF_FFFF, 32'd5);          // tick wrap
                add_frame(32'h0, 32'hFFFF_FFFF);
                // flush the window with zero frame times so the sum drops to zero
                repeat (WINDOW) add_frame(32'hFFFF_FFFF, 32'hFFFF_FFFF);
                add_frame(32'hFFFF_FFFF, 32'h0);          // one tick over nine zeros: top rate
                add_frame(32'h5555_5555, 32'hAAAA_AAAA);
                add_frame(32'hAAAA_AAAA, 32'h5555_5555);
                gen_end = 32'h5555_5555;
            end
            for (int n = 0; n < RAND_FRAMES; n++) begin
                pick = $urandom_range(0, 99);
                if (pick < 78) begin
                    case ($urandom_range(0, 9))
                        0:       delta = 0;
                        1:       delta = $urandom_range(60000, 70000);
                        2:       delta = $urandom;
                        default: delta = $urandom_range(1, 50);
                    endcase
                    case ($urandom_range(0, 7))
                        0:       busy = budget_now;
                        1:       busy = budget_now - 1;
                        2:       busy = -TICK_W'($urandom_range(1, 5));
                        default: busy = $urandom_range(0, budget_now + 3);
                    endcase
                    end_tick = gen_end + delta;
                    add_frame(end_tick - busy, end_tick);
                end else if (pick < 90) begin
                    // backward jump in the tick count
                    end_tick = gen_end - TICK_W'($urandom_range(1, 1000));
                    add_frame(end_tick - TICK_W'($urandom_range(0, budget_now)), end_tick);
                end else begin
                    end_tick = $urandom;
                    add_frame($urandom, end_tick);
                end
                gen_end = end_tick;
            end
            // hold off the output while the sender keeps offering words
            if (phase == 4 || phase == 7) holds_asked++;
            wait_until_drained();
        end
        wait_until_drained();
        repeat (60) @(posedge i_clk);
        if (errors == 0 && expected_results.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
